FILE: design/dlt_pkg.sv
// Shared constants and fixed-point helpers for the DH link transform.
// Depends on nothing; used by dlt_sincos, dlt_matrix and dh_link_transform.
package dlt_pkg;

    // round(2^28 / (2*pi)): Q.12 angle to 24-bit turn fraction
    localparam logic signed [26:0] TURN_SCALE = 27'sd42722830;

    localparam int HORNER_N = 4;
    localparam logic signed [31:0] POLY_A9 = 32'sd172272;
    localparam logic signed [31:0] HORNER_C [HORNER_N] = '{
        32'sd5026995, 32'sd85569306, 32'sd693598668, 32'sd1686629713
    };

    localparam logic [16:0] ONE_Q14 = 17'd16384;

    // sincos pipeline depth, LAT adds the matrix stage on top
    localparam int SC_LAT = 9;
    localparam int LAT    = SC_LAT + 1;

    // (a*b) >> 30, rounded half away from zero, b non-negative
    function automatic logic signed [31:0] rmul30(input logic signed [31:0] a,
                                                  input logic [30:0] b);
        logic [31:0] mag;
        logic [62:0] p;
        logic [32:0] q;
        mag = a[31] ? 32'(-a) : 32'(a);
        p   = 63'(mag) * 63'(b);
        q   = 33'((p + (63'd1 << 29)) >> 30);
        return a[31] ? 32'(-q) : 32'(q);
    endfunction

    // (a*b) >> 14, rounded half away from zero
    function automatic logic signed [26:0] rmul14(input logic signed [23:0] a,
                                                  input logic signed [15:0] b);
        logic [23:0] ma;
        logic [15:0] mb;
        logic [39:0] p;
        logic [25:0] q;
        ma = a[23] ? 24'(-a) : 24'(a);
        mb = b[15] ? 16'(-b) : 16'(b);
        p  = 40'(ma) * 40'(mb);
        q  = 26'((p + 40'd8192) >> 14);
        return (a[23] != b[15]) ? 27'(-$signed({1'b0, q})) : $signed({1'b0, q});
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -27'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

endpackage

FILE: design/dh_link_transform.sv
// Top level of the DH link transform: input mux, two sincos pipes, matrix stage.
// Depends on dlt_pkg, dlt_sincos and dlt_matrix.
// One link per cycle sustained unless the output stalls; each accepted transfer
// passes nine sincos stages plus one product stage to the output. The whole
// pipeline advances together and holds while the output transfer is stalled.
module dh_link_transform (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_joint_is_prismatic,
    input  logic signed [23:0] s_joint_value,
    input  logic signed [15:0] s_fixed_theta,
    input  logic signed [15:0] s_link_twist,
    input  logic signed [23:0] s_fixed_offset,
    input  logic signed [23:0] s_normal_length,
    input  logic               s_last_link,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_m00,
    output logic signed [15:0] m_m01,
    output logic signed [15:0] m_m02,
    output logic signed [23:0] m_m03,
    output logic signed [15:0] m_m10,
    output logic signed [15:0] m_m11,
    output logic signed [15:0] m_m12,
    output logic signed [23:0] m_m13,
    output logic signed [15:0] m_m21,
    output logic signed [15:0] m_m22,
    output logic signed [23:0] m_m23,
    output logic               m_last_out
);
    localparam int SL = dlt_pkg::SC_LAT;
    localparam int LT = dlt_pkg::LAT;

    logic               en;
    logic [LT-1:0]      vld_reg;
    logic signed [23:0] a_reg [SL];
    logic signed [23:0] d_reg [SL];
    logic               last_reg [LT];
    logic signed [23:0] theta;
    logic signed [15:0] st, ct, sa, ca;

    assign en      = !vld_reg[LT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LT-1];
    assign theta   = s_joint_is_prismatic ? 24'(s_fixed_theta) : s_joint_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0]    <= s_normal_length;
            d_reg[0]    <= s_joint_is_prismatic ? s_joint_value : s_fixed_offset;
            last_reg[0] <= s_last_link;
            for (int i = 1; i < SL; i++) begin
                a_reg[i] <= a_reg[i-1];
                d_reg[i] <= d_reg[i-1];
            end
            for (int i = 1; i < LT; i++)
                last_reg[i] <= last_reg[i-1];
        end
    end

    dlt_sincos u_theta (
        .aclk    (aclk),
        .en      (en),
        .angle   (theta),
        .sin_q14 (st),
        .cos_q14 (ct)
    );

    dlt_sincos u_alpha (
        .aclk    (aclk),
        .en      (en),
        .angle   (24'(s_link_twist)),
        .sin_q14 (sa),
        .cos_q14 (ca)
    );

    dlt_matrix u_matrix (
        .aclk (aclk),
        .en   (en),
        .st   (st),
        .ct   (ct),
        .sa   (sa),
        .ca   (ca),
        .a    (a_reg[SL-1]),
        .d    (d_reg[SL-1]),
        .m00  (m_m00),
        .m01  (m_m01),
        .m02  (m_m02),
        .m03  (m_m03),
        .m10  (m_m10),
        .m11  (m_m11),
        .m12  (m_m12),
        .m13  (m_m13),
        .m21  (m_m21),
        .m22  (m_m22),
        .m23  (m_m23)
    );

    assign m_last_out = last_reg[LT-1];
endmodule

FILE: design/dlt_sincos.sv
// Pipelined sine/cosine: angle to turn phase, quarter-wave polynomial in
// Horner stages, quadrant fold. Nine register stages. Uses dlt_pkg.
module dlt_sincos (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [23:0] angle,
    output logic signed [15:0] sin_q14,
    output logic signed [15:0] cos_q14
);
    localparam int HN = dlt_pkg::HORNER_N;

    logic [39:0]        prod_reg;
    logic [30:0]        x_reg  [2][HN+2];
    logic [30:0]        x2_reg [2][HN];
    logic signed [31:0] s_reg  [2][HN];
    logic signed [31:0] sx_reg [2];
    logic [1:0]         q_reg  [HN+3];
    logic signed [15:0] sin_reg, cos_reg;

    logic [39:0] ph;
    logic [21:0] r;
    logic [22:0] r_hi;
    logic [15:0] lo, hi;
    logic signed [50:0] full;

    function automatic logic [15:0] to_q14(input logic signed [31:0] s);
        logic [31:0] mag;
        logic [16:0] q;
        mag = s[31] ? 32'(-s) : 32'(s);
        q   = 17'((33'(mag) + 33'd32768) >> 16);
        if (s[31] && q != 17'd0)
            return 16'd0;
        else if (q > dlt_pkg::ONE_Q14)
            return 16'(dlt_pkg::ONE_Q14);
        else
            return q[15:0];
    endfunction

    always_comb begin
        full = 51'(angle) * 51'(dlt_pkg::TURN_SCALE);
        ph   = prod_reg + (40'd1 << 15);
        r    = ph[37:16];
        r_hi = 23'h400000 - 23'(r);
        lo   = to_q14(sx_reg[0]);
        hi   = to_q14(sx_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= full[39:0];
            q_reg[0] <= ph[39:38];
            for (int i = 1; i < HN + 3; i++)
                q_reg[i] <= q_reg[i-1];
            x_reg[0][0] <= {1'b0, r, 8'd0};
            x_reg[1][0] <= {r_hi, 8'd0};
            for (int k = 0; k < 2; k++) begin
                for (int i = 1; i < HN + 2; i++)
                    x_reg[k][i] <= x_reg[k][i-1];
                x2_reg[k][0] <= 31'((62'(x_reg[k][0]) * 62'(x_reg[k][0])
                                     + (62'd1 << 29)) >> 30);
                for (int i = 1; i < HN; i++)
                    x2_reg[k][i] <= x2_reg[k][i-1];
                s_reg[k][0] <= dlt_pkg::HORNER_C[0]
                               - dlt_pkg::rmul30(dlt_pkg::POLY_A9, x2_reg[k][0]);
                for (int j = 1; j < HN; j++)
                    s_reg[k][j] <= dlt_pkg::HORNER_C[j]
                                   - dlt_pkg::rmul30(s_reg[k][j-1], x2_reg[k][j]);
                sx_reg[k] <= dlt_pkg::rmul30(s_reg[k][HN-1], x_reg[k][HN+1]);
            end
            unique case (q_reg[HN+2])
                2'd0: begin sin_reg <= lo;           cos_reg <= hi;           end
                2'd1: begin sin_reg <= hi;           cos_reg <= 16'(-$signed(lo)); end
                2'd2: begin sin_reg <= 16'(-$signed(lo)); cos_reg <= 16'(-$signed(hi)); end
                default: begin sin_reg <= 16'(-$signed(hi)); cos_reg <= lo;      end
            endcase
        end
    end

    assign sin_q14 = sin_reg;
    assign cos_q14 = cos_reg;
endmodule

FILE: design/dlt_matrix.sv
// Final stage: rotation and translation products of the DH matrix.
// One register stage. Uses dlt_pkg helpers.
module dlt_matrix (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] st,
    input  logic signed [15:0] ct,
    input  logic signed [15:0] sa,
    input  logic signed [15:0] ca,
    input  logic signed [23:0] a,
    input  logic signed [23:0] d,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [23:0] m03,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [23:0] m13,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22,
    output logic signed [23:0] m23
);
    logic signed [15:0] m00_reg, m01_reg, m02_reg, m10_reg, m11_reg, m12_reg;
    logic signed [15:0] m21_reg, m22_reg;
    logic signed [23:0] m03_reg, m13_reg, m23_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m00_reg <= ct;
            m10_reg <= st;
            m21_reg <= sa;
            m22_reg <= ca;
            m23_reg <= d;
            m01_reg <= 16'(-dlt_pkg::rmul14(24'(ca), st));
            m02_reg <= 16'(dlt_pkg::rmul14(24'(sa), st));
            m11_reg <= 16'(dlt_pkg::rmul14(24'(ca), ct));
            m12_reg <= 16'(-dlt_pkg::rmul14(24'(sa), ct));
            m03_reg <= dlt_pkg::sat24(dlt_pkg::rmul14(a, ct));
            m13_reg <= dlt_pkg::sat24(dlt_pkg::rmul14(a, st));
        end
    end

    assign m00 = m00_reg;
    assign m01 = m01_reg;
    assign m02 = m02_reg;
    assign m03 = m03_reg;
    assign m10 = m10_reg;
    assign m11 = m11_reg;
    assign m12 = m12_reg;
    assign m13 = m13_reg;
    assign m21 = m21_reg;
    assign m22 = m22_reg;
    assign m23 = m23_reg;
endmodule
